// ----- rtl/point_splat_top_k_depth_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the point splat top-k depth unit
// Shared property forms used by the checker; clock and reset are taken
// from the scope of the use.
// ---------------------------------------------------------------------------
`ifndef POINT_SPLAT_TOP_K_DEPTH_UNIT_DEFINES_SVH
`define POINT_SPLAT_TOP_K_DEPTH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PSTKD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pstkd check failed");

// Next-cycle implication, disabled while reset is held.
`define PSTKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pstkd check failed");

// Next-cycle implication that also watches the reset itself.
`define PSTKD_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pstkd reset check failed");

`endif

// ----- rtl/pstkd_pkg.sv -----
// ---------------------------------------------------------------------------
// pstkd_pkg
// Types, constants and the tuple ordering shared by the top-k depth unit.
// ---------------------------------------------------------------------------
package pstkd_pkg;

  localparam int MAX_K       = 8;
  localparam int INDEX_BITS  = 20;
  localparam int CNT_W       = $clog2(MAX_K + 1);
  localparam int SLOT_W      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 23;
  localparam int PIDX_W   = 20;
  localparam int DEPTH_W  = 24;
  localparam int DIST2_W  = 48;
  localparam int SUM_W    = 50;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 104;

  localparam logic [3:0]         K_RESET   = 4'd8;
  localparam logic [DIST2_W-1:0] DIST2_MAX = '1;

  // One classified point on its way from the front end to the list.
  typedef struct packed {
    logic                  hit;
    logic [DEPTH_W-1:0]    depth;
    logic [INDEX_BITS-1:0] index;
    logic [DIST2_W-1:0]    dist2;
    logic                  last;
  } hit_item_t;

  // One result word before packing.
  typedef struct packed {
    logic [2:0]  slot;
    logic [20:0] hit_index;
    logic [23:0] hit_depth;
    logic [48:0] hit_dist2;
    logic        last_result;
  } result_t;

  // True when tuple a orders strictly before tuple b.
  function automatic logic tuple_less(input logic [DEPTH_W-1:0]    da,
                                      input logic [INDEX_BITS-1:0] ia,
                                      input logic [DIST2_W-1:0]    sa,
                                      input logic [DEPTH_W-1:0]    db,
                                      input logic [INDEX_BITS-1:0] ib,
                                      input logic [DIST2_W-1:0]    sb);
    logic res;
    if (da != db) begin
      res = (da < db);
    end else if (ia != ib) begin
      res = (ia < ib);
    end else begin
      res = (sa < sb);
    end
    return res;
  endfunction

endpackage

// ----- rtl/point_splat_top_k_depth_unit.sv -----
// ---------------------------------------------------------------------------
// point_splat_top_k_depth_unit
// Keeps the k nearest-depth point hits of one pixel and emits them sorted.
// ---------------------------------------------------------------------------
// Use: the points of one pixel stream in on the in_ channel, one word per
// point, each carrying the pixel centre; in_tlast marks the final point of
// the pixel. After that point the block emits k_in_use words on the out_
// channel, slot 0 (nearest depth) first, empty slots padded with all ones,
// out_tlast on the final slot. cfg_wr_en writes k_in_use (reset value 8).
// Throughput: one point per cycle unless the queue backs up, set by the
// two-stage distance pipe and the parallel insert into the sorted list.
// Results drain one slot per cycle, while the receiver takes them, from a
// bank that is loaded when a pixel closes, so a new pixel fills while the
// previous one drains; a pixel end stalls only while the bank still holds
// an earlier pixel.
// Reset clears the list count, the queue and the result bank and sets
// k_in_use to 8. When the receiver stalls, the bank holds its word, the
// queue fills and in_tready falls back to the source.
// ---------------------------------------------------------------------------
module point_splat_top_k_depth_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [3:0]                          cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pixel_x, pixel_y, point_x, point_y, point_z, point_radius, point_index
  input  logic [pstkd_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // slot, hit_index, hit_depth, hit_dist2
  output logic [pstkd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  logic                 push_valid, push_ready, pop_valid, pop_ready;
  pstkd_pkg::hit_item_t push_data, pop_data;
  pstkd_pkg::result_t   res_data;

  pstkd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .pixel_x      (in_tdata[23:0]),
    .pixel_y      (in_tdata[47:24]),
    .point_x      (in_tdata[71:48]),
    .point_y      (in_tdata[95:72]),
    .point_z      (in_tdata[119:96]),
    .point_radius (in_tdata[142:120]),
    .point_index  (in_tdata[162:143]),
    .last_point   (in_tlast),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  pstkd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pstkd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_data    (res_data)
  );

  assign out_tdata = {7'd0, res_data.hit_dist2, res_data.hit_depth,
                      res_data.hit_index, res_data.slot};
  assign out_tlast = res_data.last_result;

endmodule

// ----- rtl/pstkd_front.sv -----
// ---------------------------------------------------------------------------
// pstkd_front
// Accepts points, works out the squared distance and radius test over two
// stages and pushes hits and pixel ends into the queue.
// ---------------------------------------------------------------------------
module pstkd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pstkd_pkg::COORD_W-1:0]  pixel_x,
  input  logic signed [pstkd_pkg::COORD_W-1:0]  pixel_y,
  input  logic signed [pstkd_pkg::COORD_W-1:0]  point_x,
  input  logic signed [pstkd_pkg::COORD_W-1:0]  point_y,
  input  logic signed [pstkd_pkg::COORD_W-1:0]  point_z,
  input  logic        [pstkd_pkg::RADIUS_W-1:0] point_radius,
  input  logic        [pstkd_pkg::PIDX_W-1:0]   point_index,
  input  logic                                last_point,
  output logic                                push_valid,
  input  logic                                push_ready,
  output pstkd_pkg::hit_item_t                push_data
);

  // Stage one: differences.
  logic                                   v1_r;
  logic signed [pstkd_pkg::COORD_W:0]     dx1_r, dy1_r;
  logic        [pstkd_pkg::RADIUS_W-1:0]  r1_r;
  logic                                   neg1_r;
  logic        [pstkd_pkg::DEPTH_W-1:0]   z1_r;
  logic        [pstkd_pkg::INDEX_BITS-1:0] idx1_r;
  logic                                   last1_r;

  // Stage two: products.
  logic                                   v2_r;
  logic        [pstkd_pkg::SUM_W-2:0]     dxx2_r, dyy2_r;
  logic        [2*pstkd_pkg::RADIUS_W-1:0] rr2_r;
  logic                                   neg2_r;
  logic        [pstkd_pkg::DEPTH_W-1:0]   z2_r;
  logic        [pstkd_pkg::INDEX_BITS-1:0] idx2_r;
  logic                                   last2_r;

  logic signed [2*pstkd_pkg::COORD_W+1:0] sq_x, sq_y;
  logic        [pstkd_pkg::SUM_W-1:0]     d2;
  logic                                   hit;
  logic                                   keep;
  logic                                   adv1, adv2;

  assign sq_x = dx1_r * dx1_r;
  assign sq_y = dy1_r * dy1_r;

  always_comb begin
    d2   = {1'b0, dxx2_r} + {1'b0, dyy2_r};
    hit  = !neg2_r && (d2 < pstkd_pkg::SUM_W'(rr2_r));
    keep = hit || last2_r;
    push_valid          = v2_r && keep;
    push_data.hit       = hit;
    push_data.depth     = z2_r;
    push_data.index     = idx2_r;
    push_data.dist2     = (d2 > {2'b00, pstkd_pkg::DIST2_MAX}) ? pstkd_pkg::DIST2_MAX
                                                               : d2[pstkd_pkg::DIST2_W-1:0];
    push_data.last      = last2_r;
  end

  // A missed point that does not close a pixel simply leaves stage two.
  assign adv2     = !v2_r || push_ready || !keep;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      dx1_r   <= {point_x[pstkd_pkg::COORD_W-1], point_x}
               - {pixel_x[pstkd_pkg::COORD_W-1], pixel_x};
      dy1_r   <= {point_y[pstkd_pkg::COORD_W-1], point_y}
               - {pixel_y[pstkd_pkg::COORD_W-1], pixel_y};
      r1_r    <= point_radius;
      neg1_r  <= point_z[pstkd_pkg::COORD_W-1];
      z1_r    <= point_z;
      idx1_r  <= pstkd_pkg::INDEX_BITS'(point_index);
      last1_r <= last_point;
    end
    if (adv2) begin
      dxx2_r  <= sq_x[pstkd_pkg::SUM_W-2:0];
      dyy2_r  <= sq_y[pstkd_pkg::SUM_W-2:0];
      rr2_r   <= r1_r * r1_r;
      neg2_r  <= neg1_r;
      z2_r    <= z1_r;
      idx2_r  <= idx1_r;
      last2_r <= last1_r;
    end
  end

endmodule

// ----- rtl/pstkd_queue.sv -----
// ---------------------------------------------------------------------------
// pstkd_queue
// Short first-in first-out queue of classified points between the front
// end and the list.
// ---------------------------------------------------------------------------
module pstkd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  pstkd_pkg::hit_item_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output pstkd_pkg::hit_item_t pop_data
);

  pstkd_pkg::hit_item_t          mem_r [pstkd_pkg::QUEUE_DEPTH];
  logic [pstkd_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [pstkd_pkg::QPTR_W:0]    count_r, count_nxt;
  logic                          do_push, do_pop;

  assign push_ready = (count_r != (pstkd_pkg::QPTR_W+1)'(pstkd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- rtl/pstkd_back.sv -----
// ---------------------------------------------------------------------------
// pstkd_back
// Keeps the sorted list of nearest hits, inserting one word a cycle unless a
// pixel end waits for the result bank, and hands the list of a finished
// pixel to a result bank that drains slot by slot.
// ---------------------------------------------------------------------------
module pstkd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [3:0]           cfg_wr_data,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  pstkd_pkg::hit_item_t pop_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pstkd_pkg::result_t   res_data
);

  localparam int K = pstkd_pkg::MAX_K;

  logic [3:0] k_cfg_r;

  logic [pstkd_pkg::DEPTH_W-1:0]    kept_depth_r [K], kept_depth_nxt [K];
  logic [pstkd_pkg::INDEX_BITS-1:0] kept_index_r [K], kept_index_nxt [K];
  logic [pstkd_pkg::DIST2_W-1:0]    kept_dist2_r [K], kept_dist2_nxt [K];
  logic [pstkd_pkg::CNT_W-1:0]      kept_count_r, kept_count_nxt;

  logic [pstkd_pkg::DEPTH_W-1:0]    bank_depth_r [K];
  logic [pstkd_pkg::INDEX_BITS-1:0] bank_index_r [K];
  logic [pstkd_pkg::DIST2_W-1:0]    bank_dist2_r [K];
  logic [pstkd_pkg::CNT_W-1:0]      bank_cnt_r, bank_k_r;
  logic [pstkd_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic                             bank_valid_r, bank_valid_nxt;

  logic [pstkd_pkg::CNT_W-1:0] k_eff, cnt, cnt_after;
  logic [K-1:0]                lt, gt;
  logic                        fire, ins, load, bank_free, out_fire, out_last;
  logic                        filled;

  always_comb begin
    if (k_cfg_r == '0) begin
      k_eff = pstkd_pkg::CNT_W'(1);
    end else if (32'(k_cfg_r) > K) begin
      k_eff = pstkd_pkg::CNT_W'(K);
    end else begin
      k_eff = pstkd_pkg::CNT_W'(k_cfg_r);
    end
    // A lowered k cuts the list before anything else happens.
    cnt = (kept_count_r > k_eff) ? k_eff : kept_count_r;
  end

  // Output side of the result bank.
  assign out_last  = (pstkd_pkg::CNT_W'(slot_r) == bank_k_r - pstkd_pkg::CNT_W'(1));
  assign out_fire  = bank_valid_r && res_ready;
  assign bank_free = !bank_valid_r || (res_ready && out_last);
  assign pop_ready = !pop_data.last || bank_free;
  assign fire      = pop_valid && pop_ready;
  assign load      = fire && pop_data.last;

  // Every slot compares against the new tuple at once; gt marks the slots at
  // or after the insertion point.
  always_comb begin
    for (int i = 0; i < K; i++) begin
      lt[i] = (pstkd_pkg::CNT_W'(i) < cnt)
              && pstkd_pkg::tuple_less(pop_data.depth, pop_data.index, pop_data.dist2,
                                       kept_depth_r[i], kept_index_r[i], kept_dist2_r[i]);
      gt[i] = !(pstkd_pkg::CNT_W'(i) < cnt) || lt[i];
    end
    ins = fire && pop_data.hit && ((cnt < k_eff) || (|lt));
    cnt_after = (ins && (cnt < k_eff)) ? cnt + pstkd_pkg::CNT_W'(1) : cnt;

    for (int i = 0; i < K; i++) begin
      kept_depth_nxt[i] = kept_depth_r[i];
      kept_index_nxt[i] = kept_index_r[i];
      kept_dist2_nxt[i] = kept_dist2_r[i];
      if (ins && (pstkd_pkg::CNT_W'(i) < k_eff) && gt[i]) begin
        if (i == 0 || !gt[(i == 0) ? 0 : i-1]) begin
          kept_depth_nxt[i] = pop_data.depth;
          kept_index_nxt[i] = pop_data.index;
          kept_dist2_nxt[i] = pop_data.dist2;
        end else begin
          kept_depth_nxt[i] = kept_depth_r[(i == 0) ? 0 : i-1];
          kept_index_nxt[i] = kept_index_r[(i == 0) ? 0 : i-1];
          kept_dist2_nxt[i] = kept_dist2_r[(i == 0) ? 0 : i-1];
        end
      end
    end

    if (load) begin
      kept_count_nxt = '0;
    end else if (fire) begin
      kept_count_nxt = cnt_after;
    end else begin
      kept_count_nxt = kept_count_r;
    end
  end

  always_comb begin
    bank_valid_nxt = bank_valid_r;
    slot_nxt       = slot_r;
    if (out_fire) begin
      if (out_last) begin
        bank_valid_nxt = 1'b0;
      end else begin
        slot_nxt = slot_r + pstkd_pkg::SLOT_W'(1);
      end
    end
    if (load) begin
      bank_valid_nxt = 1'b1;
      slot_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_cfg_r      <= pstkd_pkg::K_RESET;
      kept_count_r <= '0;
      bank_valid_r <= 1'b0;
      slot_r       <= '0;
    end else begin
      if (cfg_wr_en) k_cfg_r <= cfg_wr_data;
      kept_count_r <= kept_count_nxt;
      bank_valid_r <= bank_valid_nxt;
      slot_r       <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < K; i++) begin
      kept_depth_r[i] <= kept_depth_nxt[i];
      kept_index_r[i] <= kept_index_nxt[i];
      kept_dist2_r[i] <= kept_dist2_nxt[i];
      if (load) begin
        bank_depth_r[i] <= kept_depth_nxt[i];
        bank_index_r[i] <= kept_index_nxt[i];
        bank_dist2_r[i] <= kept_dist2_nxt[i];
      end
    end
    if (load) begin
      bank_cnt_r <= cnt_after;
      bank_k_r   <= k_eff;
    end
  end

  assign filled    = (pstkd_pkg::CNT_W'(slot_r) < bank_cnt_r);
  assign res_valid = bank_valid_r;

  always_comb begin
    res_data.slot        = 3'(slot_r);
    res_data.hit_index   = filled ? 21'(bank_index_r[slot_r]) : '1;
    res_data.hit_depth   = filled ? bank_depth_r[slot_r] : '1;
    res_data.hit_dist2   = filled ? {1'b0, bank_dist2_r[slot_r]} : '1;
    res_data.last_result = out_last;
  end

endmodule

// ----- rtl/pstkd_checker.sv -----
// ---------------------------------------------------------------------------
// pstkd_checker
// Port-level checks on the result channel of the top-k depth unit.
// ---------------------------------------------------------------------------
`include "point_splat_top_k_depth_unit_defines.svh"

module pstkd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pstkd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  // A stalled word must not change under the receiver.
  `PSTKD_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Within a pixel the slots follow one another without a gap.
  `PSTKD_ASSERT_NEXT(a_slot_step, out_tvalid && out_tready && !out_tlast,
                     out_tvalid && (out_tdata[2:0] == $past(out_tdata[2:0]) + 3'd1))

  // A pixel that follows straight on from a final slot starts again at slot zero.
  `PSTKD_ASSERT_NEXT(a_slot_restart, out_tvalid && out_tready && out_tlast,
                     !out_tvalid || (out_tdata[2:0] == 3'd0))

  // An empty slot is padded in all three fields together.
  `PSTKD_ASSERT_NOW(a_pad, out_tvalid && (out_tdata[23:3] == '1),
                    (out_tdata[47:24] == '1) && (out_tdata[96:48] == '1))

  // Reset empties the result bank.
  `PSTKD_ASSERT_RST(a_reset, !rst_n, !out_tvalid)

endmodule

bind point_splat_top_k_depth_unit pstkd_checker u_pstkd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
